@@ rtl/core/wcvs_pkg.sv @@
// ----------------------------------------------------------------------------
// Weighted cache victim selector package
// Transaction types, entry layout, controller/datapath interface, constants.
// ----------------------------------------------------------------------------
package wcvs_pkg;

  localparam int HANDLE_W = 6;
  localparam int TIME_W   = 63;
  localparam int FACTOR_W = 32;
  localparam int SIZE_W   = 32;
  localparam int PRIO_W   = 3;
  localparam int STAT_W   = 2;
  // (size + 10) * 100000 fits 50 bits, times (prio + 1) fits 53 bits
  localparam int PROD_W   = 50;
  localparam int NUM_W    = 53;
  localparam int DCNT_W   = 6;

  localparam logic [FACTOR_W-1:0] FACTOR_INIT  = 32'hFFFF_FFFD;
  localparam logic [FACTOR_W-1:0] FACTOR_CLEAR = 32'hFFFF_FFFE;
  localparam logic [FACTOR_W-1:0] FACTOR_MAX   = 32'hFFFF_FFFF;
  localparam logic [PRIO_W-1:0]   MEDIUM_PRIORITY = 3'd1;
  localparam logic [STAT_W-1:0]   ST_NOT_CACHED   = 2'd0;
  localparam logic [SIZE_W:0]     SIZE_BIAS = 33'd10;
  // 1e6 / 10 from the factor formula
  localparam logic [16:0]         SCALE     = 17'd100000;

  typedef enum logic [3:0] {
    OP_INIT          = 4'd0,
    OP_CLEAR         = 4'd1,
    OP_UPDATE_FACTOR = 4'd2,
    OP_SET_SIZE      = 4'd3,
    OP_SET_STATUS    = 4'd4,
    OP_INVALIDATE    = 4'd5,
    OP_FIND_VICTIM   = 4'd6,
    OP_ADD_USAGE     = 4'd7,
    OP_SUB_USAGE     = 4'd8,
    OP_READ_ENTRY    = 4'd9,
    OP_CLEAR_ALL     = 4'd10
  } op_e;

  typedef struct packed {
    logic [3:0]          operation;
    logic [HANDLE_W-1:0] handle;
    logic [PRIO_W-1:0]   affinity;
    logic [SIZE_W-1:0]   size_bytes;
    logic [STAT_W-1:0]   status;
    logic [FACTOR_W-1:0] start_value;
    logic [TIME_W-1:0]   time_ns;
  } in_t;

  typedef struct packed {
    logic                victim_found;
    logic [HANDLE_W-1:0] victim_handle;
    logic [SIZE_W-1:0]   entry_size;
    logic [STAT_W-1:0]   entry_status;
    logic [SIZE_W-1:0]   cache_usage;
  } out_t;

  typedef struct packed {
    logic                occupied;
    logic [SIZE_W-1:0]   file_size;
    logic [PRIO_W-1:0]   prio;
    logic [STAT_W-1:0]   ent_state;
    logic [FACTOR_W-1:0] factor;
    logic [TIME_W-1:0]   last_access;
  } entry_t;

  typedef struct packed {
    logic capture;
    logic rd_handle;
    logic rd_scan;
    logic load_ent;
    logic cnt_clr;
    logic cnt_inc;
    logic sweep_wr;
    logic sweep_rst;
    logic scan_init;
    logic mul0;
    logic mul1;
    logic div_step;
    logic entry_wr;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic [3:0] operation;
    logic       ok;
    logic       cnt_last;
    logic       div_last;
    logic       out_free;
  } sts_t;

  function automatic entry_t wipe_entry(input logic [TIME_W-1:0] t);
    entry_t e;
    e.occupied    = 1'b0;
    e.file_size   = '0;
    e.prio        = MEDIUM_PRIORITY;
    e.ent_state   = ST_NOT_CACHED;
    e.factor      = FACTOR_CLEAR;
    e.last_access = t;
    return e;
  endfunction

endpackage

@@ rtl/core/wcvs_controller.sv @@
// ----------------------------------------------------------------------------
// Weighted cache victim selector controller
// Sequences table access, sweep, scan, factor divide and result hand-off.
// ----------------------------------------------------------------------------
module wcvs_controller (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  wcvs_pkg::sts_t sts_i,
  output wcvs_pkg::cmd_t cmd_o
);
  import wcvs_pkg::*;

  localparam logic [3:0] S_RST_CLR = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_READ    = 4'd2;
  localparam logic [3:0] S_LOAD    = 4'd3;
  localparam logic [3:0] S_SWEEP   = 4'd4;
  localparam logic [3:0] S_SCAN    = 4'd5;
  localparam logic [3:0] S_TAIL    = 4'd6;
  localparam logic [3:0] S_MUL0    = 4'd7;
  localparam logic [3:0] S_MUL1    = 4'd8;
  localparam logic [3:0] S_DIV     = 4'd9;
  localparam logic [3:0] S_WRITE   = 4'd10;
  localparam logic [3:0] S_DONE    = 4'd11;

  logic [3:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_RST_CLR;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_RST_CLR: begin
        cmd_o.sweep_wr  = 1'b1;
        cmd_o.sweep_rst = 1'b1;
        cmd_o.cnt_inc   = 1'b1;
        if (sts_i.cnt_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_READ;
        end
      end
      S_READ: begin
        cmd_o.rd_handle = 1'b1;
        state_d         = S_LOAD;
      end
      S_LOAD: begin
        cmd_o.load_ent = 1'b1;
        cmd_o.cnt_clr  = 1'b1;
        case (sts_i.operation)
          OP_CLEAR_ALL: state_d = S_SWEEP;
          OP_FIND_VICTIM: begin
            cmd_o.scan_init = 1'b1;
            state_d         = S_SCAN;
          end
          OP_UPDATE_FACTOR: state_d = sts_i.ok ? S_MUL0 : S_WRITE;
          default: state_d = S_WRITE;
        endcase
      end
      S_SWEEP: begin
        cmd_o.sweep_wr = 1'b1;
        cmd_o.cnt_inc  = 1'b1;
        if (sts_i.cnt_last) begin
          state_d = S_WRITE;
        end
      end
      S_SCAN: begin
        cmd_o.rd_scan = 1'b1;
        cmd_o.cnt_inc = 1'b1;
        if (sts_i.cnt_last) begin
          state_d = S_TAIL;
        end
      end
      S_TAIL: state_d = S_DONE;
      S_MUL0: begin
        cmd_o.mul0 = 1'b1;
        state_d    = S_MUL1;
      end
      S_MUL1: begin
        cmd_o.mul1 = 1'b1;
        state_d    = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd_o.entry_wr = 1'b1;
        state_d        = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_RST_CLR;
    endcase
  end

endmodule

@@ rtl/core/wcvs_datapath.sv @@
// ----------------------------------------------------------------------------
// Weighted cache victim selector datapath
// Entry table, usage total, factor multiply/divide, victim scan, result register.
// ----------------------------------------------------------------------------
module wcvs_datapath #(
  parameter int NUM_ENTRIES = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  wcvs_pkg::in_t  in_data_i,
  input  wcvs_pkg::cmd_t cmd_i,
  output wcvs_pkg::sts_t sts_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output wcvs_pkg::out_t out_data_o
);
  import wcvs_pkg::*;

  localparam int IDX_W = $clog2(NUM_ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_ENTRIES - 1);
  localparam logic [31:0]      NUM_U    = 32'(NUM_ENTRIES);

  entry_t mem [NUM_ENTRIES];
  entry_t rdata_q;
  entry_t ent_q;
  entry_t new_ent;
  entry_t wr_data;
  in_t    req_q;
  out_t   out_q;

  logic [IDX_W-1:0] cnt_q, rd_addr, wr_addr, hidx;
  logic             wr_en, ok, ent_wr_op, out_valid_q;
  logic [TIME_W-1:0] sweep_t;

  logic [TIME_W-1:0]   elapsed_q;
  logic                sat_q;
  logic [PROD_W-1:0]   prod_q;
  logic [NUM_W-1:0]    n_q;
  logic [TIME_W-1:0]   rem_q;
  logic [DCNT_W-1:0]   div_cnt_q;
  logic [SIZE_W:0]     biased;
  logic [3:0]          weight;
  logic [TIME_W:0]     sh, diff;
  logic                ge;
  logic [FACTOR_W-1:0] fac;

  logic                scan_v_q;
  logic [IDX_W-1:0]    scan_idx_q, vh_q;
  logic [FACTOR_W-1:0] best_q;
  logic                found_q;
  logic [SIZE_W-1:0]   usage_q;
  logic                is_victim;

  assign ok        = 32'(req_q.handle) < NUM_U;
  assign hidx      = IDX_W'(req_q.handle);
  assign rd_addr   = cmd_i.rd_scan ? cnt_q : hidx;
  assign sweep_t   = cmd_i.sweep_rst ? '0 : req_q.time_ns;
  assign is_victim = (req_q.operation == OP_FIND_VICTIM);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_handle || cmd_i.rd_scan) begin
      rdata_q <= mem[rd_addr];
    end
  end

  // divider step: restoring, one quotient bit per cycle
  assign sh   = {rem_q, n_q[NUM_W-1]};
  assign ge   = sh >= {1'b0, elapsed_q};
  assign diff = sh - {1'b0, elapsed_q};
  assign fac  = (sat_q || (|n_q[NUM_W-1:FACTOR_W])) ? FACTOR_MAX : n_q[FACTOR_W-1:0];

  assign biased = {1'b0, ent_q.file_size} + SIZE_BIAS;
  assign weight = {1'b0, ent_q.prio} + 4'd1;

  always_comb begin
    new_ent   = ent_q;
    ent_wr_op = 1'b0;
    case (req_q.operation)
      OP_INIT: begin
        new_ent.occupied    = 1'b1;
        new_ent.file_size   = '0;
        new_ent.prio        = req_q.affinity;
        new_ent.ent_state   = ST_NOT_CACHED;
        new_ent.factor      = FACTOR_INIT;
        new_ent.last_access = req_q.time_ns;
        ent_wr_op           = 1'b1;
      end
      OP_CLEAR: begin
        new_ent   = wipe_entry(req_q.time_ns);
        ent_wr_op = 1'b1;
      end
      OP_UPDATE_FACTOR: begin
        new_ent.factor      = fac;
        new_ent.last_access = req_q.time_ns;
        ent_wr_op           = 1'b1;
      end
      OP_SET_SIZE: begin
        new_ent.file_size = req_q.size_bytes;
        ent_wr_op         = 1'b1;
      end
      OP_SET_STATUS: begin
        new_ent.ent_state = req_q.status;
        ent_wr_op         = 1'b1;
      end
      OP_INVALIDATE: begin
        new_ent.occupied = 1'b0;
        ent_wr_op        = 1'b1;
      end
      OP_CLEAR_ALL: new_ent = wipe_entry(req_q.time_ns);
      default: ;
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cnt_q;
    wr_data = wipe_entry(sweep_t);
    if (cmd_i.sweep_wr) begin
      wr_en = 1'b1;
    end else if (cmd_i.entry_wr && ok && ent_wr_op) begin
      wr_en   = 1'b1;
      wr_addr = hidx;
      wr_data = new_ent;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= in_data_i;
    end
    if (cmd_i.load_ent) begin
      ent_q <= rdata_q;
    end else if (cmd_i.entry_wr) begin
      ent_q <= new_ent;
    end
    if (cmd_i.mul0) begin
      elapsed_q <= req_q.time_ns - ent_q.last_access;
      sat_q     <= req_q.time_ns <= ent_q.last_access;
      prod_q    <= PROD_W'(biased) * PROD_W'(SCALE);
    end
    if (cmd_i.mul1) begin
      n_q   <= NUM_W'(prod_q) * NUM_W'(weight);
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= ge ? diff[TIME_W-1:0] : sh[TIME_W-1:0];
      n_q   <= {n_q[NUM_W-2:0], ge};
    end
    scan_idx_q <= cnt_q;
    if (cmd_i.out_load) begin
      out_q.victim_found  <= is_victim && found_q;
      out_q.victim_handle <= (is_victim && found_q) ? HANDLE_W'(vh_q) : '0;
      out_q.entry_size    <= ok ? ent_q.file_size : '0;
      out_q.entry_status  <= ok ? ent_q.ent_state : '0;
      out_q.cache_usage   <= usage_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      div_cnt_q   <= '0;
      scan_v_q    <= 1'b0;
      found_q     <= 1'b0;
      vh_q        <= '0;
      best_q      <= '0;
      usage_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.cnt_clr) begin
        cnt_q <= '0;
      end else if (cmd_i.cnt_inc) begin
        cnt_q <= (cnt_q == LAST_IDX) ? '0 : cnt_q + IDX_W'(1);
      end
      if (cmd_i.mul1) begin
        div_cnt_q <= '0;
      end else if (cmd_i.div_step) begin
        div_cnt_q <= div_cnt_q + DCNT_W'(1);
      end
      scan_v_q <= cmd_i.rd_scan;
      if (cmd_i.scan_init) begin
        best_q  <= req_q.start_value;
        found_q <= 1'b0;
        vh_q    <= '0;
      end else if (scan_v_q && rdata_q.occupied && (rdata_q.factor != '0) &&
                   (rdata_q.factor <= best_q)) begin
        best_q  <= rdata_q.factor;
        found_q <= 1'b1;
        vh_q    <= scan_idx_q;
      end
      if (cmd_i.entry_wr) begin
        if (req_q.operation == OP_ADD_USAGE) begin
          usage_q <= usage_q + req_q.size_bytes;
        end else if (req_q.operation == OP_SUB_USAGE) begin
          usage_q <= usage_q - req_q.size_bytes;
        end
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.operation = req_q.operation;
  assign sts_o.ok        = ok;
  assign sts_o.cnt_last  = (cnt_q == LAST_IDX);
  assign sts_o.div_last  = (div_cnt_q == DCNT_W'(NUM_W - 1));
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ rtl/core/weighted_cache_victim_selector.sv @@
// ----------------------------------------------------------------------------
// Weighted cache victim selector
// Cache entry table with replacement factors and a minimum-factor victim search.
// ----------------------------------------------------------------------------
// Usage:
//   One input transaction (in_valid_i/in_ready_o, in_data_i) carries one
//   operation; each produces exactly one result transaction on
//   out_valid_o/out_ready_i/out_data_o. One transaction is in work at a time.
//   Work per operation, with the table in a memory with one read port and
//   one write port, read one entry per cycle:
//     entry and usage operations     read, load, write
//     update factor                  multiply, then 53-step restoring divide
//     find victim, clear all         scan or sweep of NUM_ENTRIES (one entry a cycle)
//   in_ready_o rises in the same cycle as the result becomes valid.
//   After reset the table is swept to its reset contents with in_ready_o low.
//   A stalled receiver holds the result in the output register; the next
//   transaction is accepted and worked on meanwhile and waits only at its
//   own hand-off.
// ----------------------------------------------------------------------------
module weighted_cache_victim_selector #(
  parameter int NUM_ENTRIES = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  wcvs_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output wcvs_pkg::out_t out_data_o
);
  import wcvs_pkg::*;

  cmd_t cmd;
  sts_t sts;

  wcvs_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  wcvs_datapath #(
    .NUM_ENTRIES (NUM_ENTRIES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

@@ rtl/core/wcvs_checker.sv @@
// ----------------------------------------------------------------------------
// Weighted cache victim selector checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module wcvs_sva (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input wcvs_pkg::in_t  in_data_i,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input wcvs_pkg::out_t out_data_o
);
  import wcvs_pkg::*;

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_data_i))
    else $error("request changed while waiting");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  a_no_victim_handle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.victim_found |-> out_data_o.victim_handle == '0)
    else $error("victim handle set without victim");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second transaction accepted while busy");

  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared while idle");

endmodule

bind weighted_cache_victim_selector wcvs_sva u_wcvs_sva (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
